// File: rtl/color_temperature_to_rgb_core_assert.svh
// Assertion macros used by the checker file of the colour temperature core.
`ifndef COLOR_TEMPERATURE_TO_RGB_CORE_ASSERT_SVH
`define COLOR_TEMPERATURE_TO_RGB_CORE_ASSERT_SVH

// Same-cycle implication, reported with $error.
`define CTRGB_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, reported with $error.
`define CTRGB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/ctrgb_pkg.sv
// Constants shared by the colour temperature to RGB core.
package ctrgb_pkg;

   localparam int T_W      = 14;
   localparam int POLY_W   = 62;
   localparam int UV_FRAC  = 40;
   localparam int XZ_FRAC  = 32;
   localparam int OUT_W    = 20;
   localparam int SUM_W    = 62;
   localparam int RND_N_W  = 61;

   localparam logic [T_W-1:0] T_MIN = 14'd1000;
   localparam logic [T_W-1:0] T_MAX = 14'd15000;

   // Locus polynomial coefficients scaled by ten to the sixteenth.
   localparam logic [POLY_W-1:0] NU0 = 62'd8601177570000000;
   localparam logic [POLY_W-1:0] NU1 = 62'd1541182540000;
   localparam logic [POLY_W-1:0] NU2 = 62'd1286412120;
   localparam logic [POLY_W-1:0] DU0 = 62'd10000000000000000;
   localparam logic [POLY_W-1:0] DU1 = 62'd8424202350000;
   localparam logic [POLY_W-1:0] DU2 = 62'd7081451630;
   localparam logic [POLY_W-1:0] NV0 = 62'd3173987260000000;
   localparam logic [POLY_W-1:0] NV1 = 62'd422806245000;
   localparam logic [POLY_W-1:0] NV2 = 62'd420481691;
   localparam logic [POLY_W-1:0] DV0 = 62'd10000000000000000;
   localparam logic [POLY_W-1:0] DV1 = 62'd289741816000;
   localparam logic [POLY_W-1:0] DV2 = 62'd1614560530;

   // XYZ to linear RGB matrix scaled by ten to the seventh.
   localparam logic signed [SUM_W-1:0] M_RX = 62'sd32404542;
   localparam logic signed [SUM_W-1:0] M_RY = -62'sd15371385;
   localparam logic signed [SUM_W-1:0] M_RZ = -62'sd4985314;
   localparam logic signed [SUM_W-1:0] M_GX = -62'sd9692660;
   localparam logic signed [SUM_W-1:0] M_GY = 62'sd18760108;
   localparam logic signed [SUM_W-1:0] M_GZ = 62'sd415560;
   localparam logic signed [SUM_W-1:0] M_BX = 62'sd556434;
   localparam logic signed [SUM_W-1:0] M_BY = -62'sd2040259;
   localparam logic signed [SUM_W-1:0] M_BZ = 62'sd10572252;

   localparam logic [23:0] MAT_SCALE = 24'd10000000;
   // Ten to the seventh is an odd factor times a power of two.
   localparam int MAT_SCALE_ODD  = 78125;
   localparam int MAT_SCALE_POW2 = 7;
   localparam int OUT_MAX = 524287;
   localparam int OUT_MIN_MAG = 524288;

endpackage

// File: rtl/ctrgb_div.sv
// Pipelined restoring divider giving one quotient bit per register stage.
module ctrgb_div #(
   parameter int NUM_W   = 62,
   parameter int DEN_W   = 62,
   parameter int INT_BITS = 0,
   parameter int FRAC_Q  = 40,
   parameter int TAG_W   = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [TAG_W-1:0]  in_tag,
   output logic              out_valid,
   output logic [INT_BITS+FRAC_Q-1:0] out_quot,
   output logic [TAG_W-1:0]  out_tag
);

   localparam int STAGES = INT_BITS + FRAC_Q;
   localparam int QW     = STAGES;
   localparam int R_W    = DEN_W + INT_BITS + 1;

   logic [R_W-1:0]   rem_ff   [STAGES];
   logic [QW-1:0]    quot_ff  [STAGES];
   logic [DEN_W-1:0] den_ff   [STAGES];
   logic [TAG_W-1:0] tag_ff   [STAGES];
   logic             valid_ff [STAGES];

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      logic [R_W-1:0]   rem_src;
      logic [R_W-1:0]   rem_try;
      logic [R_W-1:0]   cmp;
      logic [QW-1:0]    quot_src;
      logic [DEN_W-1:0] den_src;
      logic [TAG_W-1:0] tag_src;
      logic             valid_src;
      logic             hit;

      if (k == 0) begin : g_first
         assign rem_src   = R_W'(in_num);
         assign quot_src  = '0;
         assign den_src   = in_den;
         assign tag_src   = in_tag;
         assign valid_src = in_valid;
      end else begin : g_next
         assign rem_src   = rem_ff[k-1];
         assign quot_src  = quot_ff[k-1];
         assign den_src   = den_ff[k-1];
         assign tag_src   = tag_ff[k-1];
         assign valid_src = valid_ff[k-1];
      end

      // Integer bits compare against a shifted divisor, fraction bits shift the remainder.
      if (k < INT_BITS) begin : g_int
         assign rem_try = rem_src;
         assign cmp     = R_W'(den_src) << (INT_BITS - 1 - k);
      end else begin : g_frac
         assign rem_try = rem_src << 1;
         assign cmp     = R_W'(den_src);
      end

      assign hit = (rem_try >= cmp);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (enable) begin
            valid_ff[k] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k]  <= hit ? (rem_try - cmp) : rem_try;
            quot_ff[k] <= (quot_src << 1) | QW'(hit);
            den_ff[k]  <= den_src;
            tag_ff[k]  <= tag_src;
         end
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_quot  = quot_ff[STAGES-1];
   assign out_tag   = tag_ff[STAGES-1];

endmodule

// File: rtl/color_temperature_to_rgb_core.sv
// Top level of the colour temperature to linear RGB conversion pipeline.
//
//   Channel   Direction   Word contents
//   req_      in          temperature_kelvin (16 bits, unsigned)
//   rsp_      out         red, green, blue (20 bits signed), was_clamped
//
// One word is accepted in every cycle while the result register is free or being taken.
// rsp_valid rises once a word has passed the bit-per-stage dividers (40 stages for u and
// v, 34 for X and Z) and eleven further register stages, three of them for the rounding
// by the matrix scale; their number does not depend on FRAC_BITS.
// Reset is synchronous and clears every valid bit; payload registers are not reset.
// When a result waits and rsp_ready is low the whole pipeline holds, so nothing is lost.
module color_temperature_to_rgb_core #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_temperature_kelvin,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [ctrgb_pkg::OUT_W-1:0] rsp_red,
   output logic signed [ctrgb_pkg::OUT_W-1:0] rsp_green,
   output logic signed [ctrgb_pkg::OUT_W-1:0] rsp_blue,
   output logic        rsp_was_clamped
);

   localparam int T_W     = ctrgb_pkg::T_W;
   localparam int POLY_W  = ctrgb_pkg::POLY_W;
   localparam int UV_FRAC = ctrgb_pkg::UV_FRAC;
   localparam int XZ_FRAC = ctrgb_pkg::XZ_FRAC;
   localparam int SUM_W   = ctrgb_pkg::SUM_W;
   localparam int RND_N_W = ctrgb_pkg::RND_N_W;
   localparam int OUT_W   = ctrgb_pkg::OUT_W;

   localparam int XZ_INT  = 2;
   localparam int XZ_Q_W  = XZ_INT + XZ_FRAC;
   localparam int XN_W    = UV_FRAC + 3;
   localparam int DEN2_W  = UV_FRAC + 1;
   localparam int ZN_W    = UV_FRAC + 5;

   // The rounding divisor is the matrix scale times the dropped fraction bits.
   localparam int RND_SHIFT = XZ_FRAC - FRAC_BITS;
   localparam int RND_DEN_W = 24 + RND_SHIFT;
   localparam logic [RND_DEN_W-1:0] RND_DEN =
      RND_DEN_W'(ctrgb_pkg::MAT_SCALE) << RND_SHIFT;
   localparam logic [RND_N_W-1:0] RND_HALF = RND_N_W'(RND_DEN >> 1);

   // The power-of-two part of the divisor is a shift; the odd part is a
   // multiplication by a rounded-up reciprocal, exact for every shifted magnitude.
   localparam int RCP_SHIFT = RND_SHIFT + ctrgb_pkg::MAT_SCALE_POW2;
   localparam int M_W       = RND_N_W - RCP_SHIFT;
   localparam int RND_Q_W   = M_W - 16;
   localparam int RCP_K     = M_W + 17;
   localparam int RCP_W     = M_W + 1;
   localparam int RCP_P2_W  = RCP_K + 1;
   localparam int M_LO_W    = M_W / 2;
   localparam int M_HI_W    = M_W - M_LO_W;
   localparam int P_LO_W    = M_LO_W + RCP_W;
   localparam int P_HI_W    = M_HI_W + RCP_W;
   localparam int P_W       = M_W + RCP_W;
   localparam logic [RCP_P2_W-1:0] RCP_P2 = RCP_P2_W'(1) << RCP_K;
   localparam logic [RCP_W-1:0] RCP =
      RCP_W'((RCP_P2 - RCP_P2_W'(1)) / RCP_P2_W'(ctrgb_pkg::MAT_SCALE_ODD) + RCP_P2_W'(1));

   localparam logic signed [SUM_W-1:0] Y_ONE = 62'sd1 <<< XZ_FRAC;

   logic rsp_valid_ff;
   logic enable;

   assign enable    = !rsp_valid_ff || rsp_ready;
   assign req_ready = enable;

   // Stage 1: clamp the temperature into range.
   logic            s1_valid_ff;
   logic [T_W-1:0]  s1_t_ff;
   logic            s1_clamp_ff;
   logic [T_W-1:0]  s1_t_in;
   logic            s1_clamp_in;

   always_comb begin
      s1_clamp_in = 1'b0;
      s1_t_in     = T_W'(req_temperature_kelvin);
      if (req_temperature_kelvin < 16'(ctrgb_pkg::T_MIN)) begin
         s1_t_in     = ctrgb_pkg::T_MIN;
         s1_clamp_in = 1'b1;
      end else if (req_temperature_kelvin > 16'(ctrgb_pkg::T_MAX)) begin
         s1_t_in     = ctrgb_pkg::T_MAX;
         s1_clamp_in = 1'b1;
      end
   end

   // Stage 2: square of the temperature.
   logic              s2_valid_ff;
   logic [T_W-1:0]    s2_t_ff;
   logic [2*T_W-1:0]  s2_t2_ff;
   logic              s2_clamp_ff;

   // Stage 3: the polynomial terms, one product each.
   logic              s3_valid_ff;
   logic              s3_clamp_ff;
   logic [POLY_W-1:0] s3_nu1_ff, s3_nu2_ff, s3_du1_ff, s3_du2_ff;
   logic [POLY_W-1:0] s3_nv1_ff, s3_nv2_ff, s3_dv1_ff, s3_dv2_ff;

   // Stage 4: numerators and denominators of u and v.
   logic              s4_valid_ff;
   logic              s4_clamp_ff;
   logic [POLY_W-1:0] s4_nu_ff, s4_du_ff, s4_nv_ff, s4_dv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (enable) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s1_t_ff     <= s1_t_in;
         s1_clamp_ff <= s1_clamp_in;

         s2_t_ff     <= s1_t_ff;
         s2_t2_ff    <= s1_t_ff * s1_t_ff;
         s2_clamp_ff <= s1_clamp_ff;

         s3_clamp_ff <= s2_clamp_ff;
         s3_nu1_ff   <= ctrgb_pkg::NU1 * POLY_W'(s2_t_ff);
         s3_nu2_ff   <= ctrgb_pkg::NU2 * POLY_W'(s2_t2_ff);
         s3_du1_ff   <= ctrgb_pkg::DU1 * POLY_W'(s2_t_ff);
         s3_du2_ff   <= ctrgb_pkg::DU2 * POLY_W'(s2_t2_ff);
         s3_nv1_ff   <= ctrgb_pkg::NV1 * POLY_W'(s2_t_ff);
         s3_nv2_ff   <= ctrgb_pkg::NV2 * POLY_W'(s2_t2_ff);
         s3_dv1_ff   <= ctrgb_pkg::DV1 * POLY_W'(s2_t_ff);
         s3_dv2_ff   <= ctrgb_pkg::DV2 * POLY_W'(s2_t2_ff);

         s4_clamp_ff <= s3_clamp_ff;
         s4_nu_ff    <= ctrgb_pkg::NU0 + s3_nu1_ff + s3_nu2_ff;
         s4_du_ff    <= ctrgb_pkg::DU0 + s3_du1_ff + s3_du2_ff;
         s4_nv_ff    <= ctrgb_pkg::NV0 + s3_nv1_ff + s3_nv2_ff;
         // The squared term always outweighs the linear one, so this stays positive.
         s4_dv_ff    <= ctrgb_pkg::DV0 + s3_dv2_ff - s3_dv1_ff;
      end
   end

   // Chromaticity u and v in UCS; both lie below one, so only fraction bits are formed.
   logic               uv_valid;
   logic               uv_clamp;
   logic [UV_FRAC-1:0] u_q;
   logic [UV_FRAC-1:0] v_q;

   ctrgb_div #(
      .NUM_W(POLY_W), .DEN_W(POLY_W), .INT_BITS(0), .FRAC_Q(UV_FRAC), .TAG_W(1)
   ) u_div_u (
      .clock(clock), .reset(reset), .enable(enable),
      .in_valid(s4_valid_ff), .in_num(s4_nu_ff), .in_den(s4_du_ff), .in_tag(s4_clamp_ff),
      .out_valid(uv_valid), .out_quot(u_q), .out_tag(uv_clamp)
   );

   ctrgb_div #(
      .NUM_W(POLY_W), .DEN_W(POLY_W), .INT_BITS(0), .FRAC_Q(UV_FRAC), .TAG_W(1)
   ) u_div_v (
      .clock(clock), .reset(reset), .enable(enable),
      .in_valid(s4_valid_ff), .in_num(s4_nv_ff), .in_den(s4_dv_ff), .in_tag(s4_clamp_ff),
      .out_valid(), .out_quot(v_q), .out_tag()
   );

   // Stage 5: numerators of X and Z over the common divisor 2v.
   logic                    s5_valid_ff;
   logic                    s5_clamp_ff;
   logic [XN_W-1:0]         s5_xn_ff;
   logic [DEN2_W-1:0]       s5_den_ff;
   logic [XN_W-1:0]         s5_zmag_ff;
   logic                    s5_zneg_ff;
   logic signed [ZN_W-1:0]  zn;

   assign zn = (ZN_W'(4) <<< UV_FRAC) - $signed(ZN_W'(u_q)) - $signed(ZN_W'(v_q) * ZN_W'(10));

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (enable) begin
         s5_valid_ff <= uv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s5_clamp_ff <= uv_clamp;
         s5_xn_ff    <= XN_W'(u_q) + (XN_W'(u_q) << 1);
         s5_den_ff   <= {v_q, 1'b0};
         s5_zneg_ff  <= zn[ZN_W-1];
         s5_zmag_ff  <= zn[ZN_W-1] ? XN_W'(-zn) : XN_W'(zn);
      end
   end

   // X and Z with Y fixed at one; both stay below four.
   logic              xz_valid;
   logic [1:0]        xz_tag;
   logic [XZ_Q_W-1:0] x_q;
   logic [XZ_Q_W-1:0] z_q;

   ctrgb_div #(
      .NUM_W(XN_W), .DEN_W(DEN2_W), .INT_BITS(XZ_INT), .FRAC_Q(XZ_FRAC), .TAG_W(2)
   ) u_div_x (
      .clock(clock), .reset(reset), .enable(enable),
      .in_valid(s5_valid_ff), .in_num(s5_xn_ff), .in_den(s5_den_ff),
      .in_tag({s5_zneg_ff, s5_clamp_ff}),
      .out_valid(xz_valid), .out_quot(x_q), .out_tag(xz_tag)
   );

   ctrgb_div #(
      .NUM_W(XN_W), .DEN_W(DEN2_W), .INT_BITS(XZ_INT), .FRAC_Q(XZ_FRAC), .TAG_W(1)
   ) u_div_z (
      .clock(clock), .reset(reset), .enable(enable),
      .in_valid(s5_valid_ff), .in_num(s5_zmag_ff), .in_den(s5_den_ff), .in_tag(s5_zneg_ff),
      .out_valid(), .out_quot(z_q), .out_tag()
   );

   logic signed [XZ_Q_W:0] x_s;
   logic signed [XZ_Q_W:0] z_s;

   assign x_s = $signed({1'b0, x_q});
   assign z_s = xz_tag[1] ? -$signed({1'b0, z_q}) : $signed({1'b0, z_q});

   // Stage 6: matrix products; stage 7: channel sums; stage 8: magnitude plus half.
   logic                    s6_valid_ff, s7_valid_ff, s8_valid_ff;
   logic                    s6_clamp_ff, s7_clamp_ff, s8_clamp_ff;
   logic signed [SUM_W-1:0] s6_rx_ff, s6_rz_ff, s6_gx_ff, s6_gz_ff, s6_bx_ff, s6_bz_ff;
   logic signed [SUM_W-1:0] s7_r_ff, s7_g_ff, s7_b_ff;
   logic [RND_N_W-1:0]      s8_rmag_ff, s8_gmag_ff, s8_bmag_ff;
   logic                    s8_rneg_ff, s8_gneg_ff, s8_bneg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
         s8_valid_ff <= 1'b0;
      end else if (enable) begin
         s6_valid_ff <= xz_valid;
         s7_valid_ff <= s6_valid_ff;
         s8_valid_ff <= s7_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s6_clamp_ff <= xz_tag[0];
         s6_rx_ff    <= ctrgb_pkg::M_RX * SUM_W'(x_s);
         s6_rz_ff    <= ctrgb_pkg::M_RZ * SUM_W'(z_s);
         s6_gx_ff    <= ctrgb_pkg::M_GX * SUM_W'(x_s);
         s6_gz_ff    <= ctrgb_pkg::M_GZ * SUM_W'(z_s);
         s6_bx_ff    <= ctrgb_pkg::M_BX * SUM_W'(x_s);
         s6_bz_ff    <= ctrgb_pkg::M_BZ * SUM_W'(z_s);

         s7_clamp_ff <= s6_clamp_ff;
         s7_r_ff     <= s6_rx_ff + ctrgb_pkg::M_RY * Y_ONE + s6_rz_ff;
         s7_g_ff     <= s6_gx_ff + ctrgb_pkg::M_GY * Y_ONE + s6_gz_ff;
         s7_b_ff     <= s6_bx_ff + ctrgb_pkg::M_BY * Y_ONE + s6_bz_ff;

         // Rounding to nearest with halves away from zero works on the magnitude.
         s8_clamp_ff <= s7_clamp_ff;
         s8_rneg_ff  <= s7_r_ff[SUM_W-1];
         s8_gneg_ff  <= s7_g_ff[SUM_W-1];
         s8_bneg_ff  <= s7_b_ff[SUM_W-1];
         s8_rmag_ff  <= RND_N_W'(s7_r_ff[SUM_W-1] ? -s7_r_ff : s7_r_ff) + RND_HALF;
         s8_gmag_ff  <= RND_N_W'(s7_g_ff[SUM_W-1] ? -s7_g_ff : s7_g_ff) + RND_HALF;
         s8_bmag_ff  <= RND_N_W'(s7_b_ff[SUM_W-1] ? -s7_b_ff : s7_b_ff) + RND_HALF;
      end
   end

   // Rounded magnitudes with the power-of-two part of the divisor shifted out.
   logic [M_W-1:0] r_m, g_m, b_m;

   assign r_m = M_W'(s8_rmag_ff >> RCP_SHIFT);
   assign g_m = M_W'(s8_gmag_ff >> RCP_SHIFT);
   assign b_m = M_W'(s8_bmag_ff >> RCP_SHIFT);

   // Joins the two partial products of the reciprocal and keeps the quotient bits.
   function automatic logic [RND_Q_W-1:0] recip_quot(input logic [P_HI_W-1:0] hi,
                                                     input logic [P_LO_W-1:0] lo);
      logic [P_W-1:0] sum;
      sum = (P_W'(hi) << M_LO_W) + P_W'(lo);
      recip_quot = RND_Q_W'(sum >> RCP_K);
   endfunction

   // Saturating sign restore for one channel.
   function automatic logic [OUT_W-1:0] saturate(input logic [RND_Q_W-1:0] q, input logic neg);
      logic [31:0] qx;
      qx = 32'(q);
      if (!neg) begin
         saturate = (qx > 32'(ctrgb_pkg::OUT_MAX)) ? OUT_W'(ctrgb_pkg::OUT_MAX) : OUT_W'(qx);
      end else begin
         saturate = (qx > 32'(ctrgb_pkg::OUT_MIN_MAG)) ?
                    OUT_W'(ctrgb_pkg::OUT_MIN_MAG) : OUT_W'(-qx);
      end
   endfunction

   // Stage 9: low and high halves of each magnitude times the reciprocal.
   // Stage 10: the partial products joined and shifted down to the quotient.
   logic                s9_valid_ff, s10_valid_ff;
   logic                s9_clamp_ff, s10_clamp_ff;
   logic                s9_rneg_ff, s9_gneg_ff, s9_bneg_ff;
   logic                s10_rneg_ff, s10_gneg_ff, s10_bneg_ff;
   logic [P_LO_W-1:0]   s9_rlo_ff, s9_glo_ff, s9_blo_ff;
   logic [P_HI_W-1:0]   s9_rhi_ff, s9_ghi_ff, s9_bhi_ff;
   logic [RND_Q_W-1:0]  s10_rq_ff, s10_gq_ff, s10_bq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s9_valid_ff  <= 1'b0;
         s10_valid_ff <= 1'b0;
      end else if (enable) begin
         s9_valid_ff  <= s8_valid_ff;
         s10_valid_ff <= s9_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s9_clamp_ff  <= s8_clamp_ff;
         s9_rneg_ff   <= s8_rneg_ff;
         s9_gneg_ff   <= s8_gneg_ff;
         s9_bneg_ff   <= s8_bneg_ff;
         s9_rlo_ff    <= P_LO_W'(r_m[M_LO_W-1:0]) * P_LO_W'(RCP);
         s9_rhi_ff    <= P_HI_W'(r_m[M_W-1:M_LO_W]) * P_HI_W'(RCP);
         s9_glo_ff    <= P_LO_W'(g_m[M_LO_W-1:0]) * P_LO_W'(RCP);
         s9_ghi_ff    <= P_HI_W'(g_m[M_W-1:M_LO_W]) * P_HI_W'(RCP);
         s9_blo_ff    <= P_LO_W'(b_m[M_LO_W-1:0]) * P_LO_W'(RCP);
         s9_bhi_ff    <= P_HI_W'(b_m[M_W-1:M_LO_W]) * P_HI_W'(RCP);

         s10_clamp_ff <= s9_clamp_ff;
         s10_rneg_ff  <= s9_rneg_ff;
         s10_gneg_ff  <= s9_gneg_ff;
         s10_bneg_ff  <= s9_bneg_ff;
         s10_rq_ff    <= recip_quot(s9_rhi_ff, s9_rlo_ff);
         s10_gq_ff    <= recip_quot(s9_ghi_ff, s9_glo_ff);
         s10_bq_ff    <= recip_quot(s9_bhi_ff, s9_blo_ff);
      end
   end

   // Stage 11: the result register.
   logic signed [OUT_W-1:0] rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic                    rsp_clamp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= s10_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_red_ff   <= saturate(s10_rq_ff, s10_rneg_ff);
         rsp_green_ff <= saturate(s10_gq_ff, s10_gneg_ff);
         rsp_blue_ff  <= saturate(s10_bq_ff, s10_bneg_ff);
         rsp_clamp_ff <= s10_clamp_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_red         = rsp_red_ff;
   assign rsp_green       = rsp_green_ff;
   assign rsp_blue        = rsp_blue_ff;
   assign rsp_was_clamped = rsp_clamp_ff;

endmodule

// File: rtl/ctrgb_checker.sv
// Port-level checks for the colour temperature core and their bind.
`include "color_temperature_to_rgb_core_assert.svh"

module ctrgb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [15:0] req_temperature_kelvin,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic signed [ctrgb_pkg::OUT_W-1:0] rsp_red,
   input logic signed [ctrgb_pkg::OUT_W-1:0] rsp_green,
   input logic signed [ctrgb_pkg::OUT_W-1:0] rsp_blue,
   input logic        rsp_was_clamped
);

   `CTRGB_ASSERT_NOW(a_ready_follows_slot, clock, reset, 1'b1, req_ready == (!rsp_valid || rsp_ready), "req_ready does not follow the result slot")
   `CTRGB_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_valid, "result valid after reset")
   `CTRGB_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_red) && $stable(rsp_green) && $stable(rsp_blue) && $stable(rsp_was_clamped), "stalled result word changed")

endmodule

bind color_temperature_to_rgb_core ctrgb_checker u_ctrgb_checker (.*);
